// ===== rtl/jacobi_symbol_unit_macros.svh =====
// ----------------------------------------------------------------------------
// jacobi symbol unit assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef JACOBI_SYMBOL_UNIT_MACROS_SVH
`define JACOBI_SYMBOL_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// clocked check, suspended while reset is high
`define JSU_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("jsu assertion failed");
// clocked check that also holds during reset
`define JSU_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("jsu assertion failed");
`else
`define JSU_ASSERT(lbl, clk, rst, prop)
`define JSU_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== rtl/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// jsu_pkg
// types and constants shared by the jacobi symbol unit modules
// ----------------------------------------------------------------------------
package jsu_pkg;

   localparam int N_W   = 32;  // numerator width
   localparam int M_W   = 31;  // modulus width
   localparam int MAG_W = 33;  // magnitude of the numerator, holds 2^31 and 2^32 - n
   localparam int SYM_W = 2;

   localparam logic [SYM_W-1:0] SYM_ZERO = 2'b00;
   localparam logic [SYM_W-1:0] SYM_POS  = 2'b01;
   localparam logic [SYM_W-1:0] SYM_NEG  = 2'b11;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT_MOD,
      ST_FIX,
      ST_CHECK,
      ST_CORE_MOD,
      ST_REDUCE,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_MOD_STEP,
      OP_FIX,
      OP_HALVE,
      OP_SWAP,
      OP_REDUCE,
      OP_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } cmd_type;

   typedef struct packed {
      logic trivial;   // incoming modulus is even or one
      logic a_zero;
      logic a_odd;
      logic mod_last;  // final step of the remainder loop
   } status_type;

endpackage

// ===== rtl/jsu_ctrl.sv =====
// ----------------------------------------------------------------------------
// jsu_ctrl
// sequencer for the jacobi symbol unit: handshakes and datapath commands
// ----------------------------------------------------------------------------
module jsu_ctrl
   import jsu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      out_free;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = status.trivial ? ST_DONE : ST_INIT_MOD;
         end
         ST_INIT_MOD: begin
            if (status.mod_last) state_in = ST_FIX;
         end
         ST_FIX:      state_in = ST_CHECK;
         ST_CHECK: begin
            if (status.a_zero)     state_in = ST_DONE;
            else if (status.a_odd) state_in = ST_CORE_MOD;
         end
         ST_CORE_MOD: begin
            if (status.mod_last) state_in = ST_REDUCE;
         end
         ST_REDUCE:   state_in = ST_CHECK;
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd.op       = OP_NONE;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (accept) cmd.op = OP_LOAD;
         end
         ST_INIT_MOD: cmd.op = OP_MOD_STEP;
         ST_FIX:      cmd.op = OP_FIX;
         ST_CHECK: begin
            if (!status.a_zero) cmd.op = status.a_odd ? OP_SWAP : OP_HALVE;
         end
         ST_CORE_MOD: cmd.op = OP_MOD_STEP;
         ST_REDUCE:   cmd.op = OP_REDUCE;
         ST_DONE: begin
            if (out_free) begin
               cmd.op       = OP_OUT;
               rsp_valid_in = 1'b1;
            end
         end
         default:     cmd.op = OP_NONE;
      endcase
   end

endmodule

// ===== rtl/jsu_dp.sv =====
// ----------------------------------------------------------------------------
// jsu_dp
// operand registers, bit-serial remainder unit, sign tracking and result beat
// ----------------------------------------------------------------------------
module jsu_dp
   import jsu_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  logic                    clock,
   input  logic signed [N_W-1:0]   req_n_value,
   input  logic        [M_W-1:0]   req_m_value,
   input  cmd_type                 cmd,
   output status_type              status,
   output logic signed [SYM_W-1:0] rsp_symbol,
   output logic                    rsp_bad_modulus
);

   // working width covers the numerator magnitude for the first reduction
   localparam int DW = (WIDTH > MAG_W) ? WIDTH : MAG_W;
   localparam int CW = $clog2(DW);
   localparam logic [DW-1:0] MASK     = ~({DW{1'b1}} << WIDTH);
   localparam logic [CW-1:0] CNT_LAST = CW'(DW - 1);

   logic [DW-1:0]    a_ff, a_in;     // numerator, dividend shifter while reducing
   logic [DW-1:0]    m_ff, m_in;
   logic [DW-1:0]    r_ff, r_in;     // partial remainder
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             s_ff, s_in;     // set when the symbol is negated
   logic             neg_ff, neg_in;
   logic             bad_ff, bad_in;
   logic [SYM_W-1:0] sym_ff, sym_in;
   logic             obad_ff, obad_in;

   logic [MAG_W-1:0] mag;
   logic [DW:0]      r_shift;
   logic [DW:0]      r_diff;
   logic             m_one;

   assign mag = req_n_value[N_W-1]
              ? (MAG_W'(1) << N_W) - {1'b0, req_n_value}
              : {1'b0, req_n_value};

   assign r_shift = {r_ff, a_ff[DW-1]};
   assign r_diff  = r_shift - {1'b0, m_ff};
   assign m_one   = (m_ff == DW'(1));

   assign status.trivial  = !req_m_value[0] || (req_m_value == M_W'(1));
   assign status.a_zero   = (a_ff == '0);
   assign status.a_odd    = a_ff[0];
   assign status.mod_last = (cnt_ff == CNT_LAST);

   always_comb begin
      a_in    = a_ff;
      m_in    = m_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      s_in    = s_ff;
      neg_in  = neg_ff;
      bad_in  = bad_ff;
      sym_in  = sym_ff;
      obad_in = obad_ff;
      case (cmd.op)
         OP_LOAD: begin
            a_in   = DW'(mag);
            m_in   = DW'(req_m_value);
            r_in   = '0;
            cnt_in = '0;
            s_in   = 1'b0;
            neg_in = req_n_value[N_W-1];
            bad_in = !req_m_value[0];
         end
         OP_MOD_STEP: begin
            a_in   = a_ff << 1;
            r_in   = r_diff[DW] ? r_shift[DW-1:0] : r_diff[DW-1:0];
            cnt_in = cnt_ff + CW'(1);
         end
         OP_FIX: begin
            // negative numerator folds back into 0 .. m-1
            a_in = ((neg_ff && (r_ff != '0)) ? (m_ff - r_ff) : r_ff) & MASK;
            m_in = m_ff & MASK;
         end
         OP_HALVE: begin
            a_in = a_ff >> 1;
            if ((m_ff[2:0] == 3'd3) || (m_ff[2:0] == 3'd5)) s_in = !s_ff;
         end
         OP_SWAP: begin
            // reciprocity: negate when both operands are 3 mod 4
            a_in   = m_ff;
            m_in   = a_ff & MASK;
            r_in   = '0;
            cnt_in = '0;
            if ((a_ff[1:0] == 2'd3) && (m_ff[1:0] == 2'd3)) s_in = !s_ff;
         end
         OP_REDUCE: begin
            a_in = r_ff & MASK;
         end
         OP_OUT: begin
            obad_in = bad_ff;
            if (bad_ff || !m_one) sym_in = SYM_ZERO;
            else                  sym_in = s_ff ? SYM_NEG : SYM_POS;
         end
         default: begin
            a_in = a_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      m_ff    <= m_in;
      r_ff    <= r_in;
      cnt_ff  <= cnt_in;
      s_ff    <= s_in;
      neg_ff  <= neg_in;
      bad_ff  <= bad_in;
      sym_ff  <= sym_in;
      obad_ff <= obad_in;
   end

   assign rsp_symbol      = sym_ff;
   assign rsp_bad_modulus = obad_ff;

endmodule

// ===== rtl/jacobi_symbol_unit.sv =====
// ----------------------------------------------------------------------------
// jacobi_symbol_unit
// jacobi symbol (n/m) of a signed numerator over an odd modulus
// ----------------------------------------------------------------------------
// usage
//   request channel: req_valid / req_stall with req_n_value (signed) and
//   req_m_value; a beat is taken when req_valid is high and req_stall low.
//   response channel: rsp_valid / rsp_stall with rsp_symbol (-1, 0, +1) and
//   rsp_bad_modulus, set with a zero symbol when the modulus is even.
//   one item is worked at a time; req_stall stays high while it runs.
//   an even modulus or a modulus of one goes straight to the result.
//   otherwise the first reduction runs the bit-serial remainder over
//   DW bits (DW = max(WIDTH, 33)); each euclid round then strips the
//   factors of two one at a time, swaps the operands and runs the
//   bit-serial remainder again, one quotient bit a cycle.
//   the result sits in an output register, so the next request is taken
//   while a finished beat still waits; a stalled beat holds, and the unit
//   waits at its end until the register frees.
//   reset (synchronous, active high) clears the sequencer and rsp_valid.
// ----------------------------------------------------------------------------
`include "jacobi_symbol_unit_macros.svh"

module jacobi_symbol_unit
   import jsu_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [N_W-1:0]   req_n_value,
   input  logic        [M_W-1:0]   req_m_value,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [SYM_W-1:0] rsp_symbol,
   output logic                    rsp_bad_modulus
);

   cmd_type    cmd;
   status_type status;

   jsu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   jsu_dp #(
      .WIDTH (WIDTH)
   ) u_dp (
      .clock           (clock),
      .req_n_value     (req_n_value),
      .req_m_value     (req_m_value),
      .cmd             (cmd),
      .status          (status),
      .rsp_symbol      (rsp_symbol),
      .rsp_bad_modulus (rsp_bad_modulus)
   );

   // a taken request keeps the unit busy on the following cycle
   `JSU_ASSERT(a_busy_after_accept, clock, reset, (req_valid && !req_stall) |=> req_stall)
   // the unused symbol code 2'b10 (-2) never appears
   `JSU_ASSERT(a_symbol_code, clock, reset, rsp_valid |-> (rsp_symbol != 2'sb10))
   // an even modulus always reports a zero symbol
   `JSU_ASSERT(a_bad_zero, clock, reset, (rsp_valid && rsp_bad_modulus) |-> (rsp_symbol == SYM_ZERO))
   // the result beat is only loaded while the output register is free
   `JSU_ASSERT_ALWAYS(a_out_only_when_free, clock, (cmd.op == OP_OUT) |-> (!rsp_valid || !rsp_stall))

endmodule

// ===== dv/jacobi_symbol_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jacobi_symbol_unit_test
// self-checking bench for the jacobi symbol unit: directed corner items, then
// random items under three source/sink idling mixes, a long sink hold-off and
// a full drain, every response beat checked against an in-bench predictor
// ----------------------------------------------------------------------------
module jacobi_symbol_unit_test;
   import jsu_pkg::*;

   localparam int HOLD_CYCLES = 400;
   localparam int QUIET_LIMIT = 20000;
   localparam int TAIL_CYCLES = 200;

   typedef struct {
      logic signed [SYM_W-1:0] symbol;
      logic                    bad_modulus;
   } jacobi_result_type;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic signed [N_W-1:0]   req_n_value;
   logic        [M_W-1:0]   req_m_value;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic signed [SYM_W-1:0] rsp_symbol;
   logic                    rsp_bad_modulus;

   jacobi_result_type pending_symbols[$];
   int  errors;
   int  items_sent;
   int  beats_checked;
   int  bad_mod_seen;
   int  neg_seen;
   int  zero_seen;
   int  quiet_cycles;
   int  source_idle_pct;
   int  sink_stall_pct;
   bit  hold_request;

   jacobi_symbol_unit uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_n_value     (req_n_value),
      .req_m_value     (req_m_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_symbol      (rsp_symbol),
      .rsp_bad_modulus (rsp_bad_modulus)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // jacobi symbol by reduction, halving and reciprocity swaps
   function automatic jacobi_result_type jacobi_of(logic signed [N_W-1:0] n,
                                                   logic [M_W-1:0] m);
      jacobi_result_type r;
      longint            sn;
      longint unsigned   a, mm, t, mag;
      bit                flip;
      r.symbol      = SYM_ZERO;
      r.bad_modulus = 1'b0;
      if (!m[0]) begin
         r.bad_modulus = 1'b1;
         return r;
      end
      if (m == M_W'(1)) begin
         r.symbol = SYM_POS;
         return r;
      end
      sn   = n;
      mm   = m;
      mag  = (sn < 0) ? -sn : sn;
      a    = mag % mm;
      if (sn < 0 && a != 0)
         a = mm - a;
      flip = 1'b0;
      while (a != 0) begin
         while (!a[0]) begin
            a = a >> 1;
            if (mm[2:0] == 3'd3 || mm[2:0] == 3'd5)
               flip = ~flip;
         end
         t  = a;
         a  = mm;
         mm = t;
         if (a[1:0] == 2'd3 && mm[1:0] == 2'd3)
            flip = ~flip;
         a = a % mm;
      end
      if (mm == 1)
         r.symbol = flip ? SYM_NEG : SYM_POS;
      return r;
   endfunction

   // sink side: random stall, or a long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_stall <= ($urandom_range(99) < sink_stall_pct);
      end
   end

   // beat monitor: checks responses, predicts on accepted requests, watchdog
   always @(posedge clock) begin
      jacobi_result_type want;
      bit                moved;
      if (!reset) begin
         moved = 1'b0;
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (pending_symbols.size() == 0) begin
               $error("response beat with nothing outstanding: symbol %0d bad_modulus %0b",
                      rsp_symbol, rsp_bad_modulus);
               errors++;
            end else begin
               want = pending_symbols.pop_front();
               beats_checked++;
               if (rsp_symbol !== want.symbol) begin
                  $error("symbol mismatch: expected %0d, got %0d", want.symbol, rsp_symbol);
                  errors++;
               end
               if (rsp_bad_modulus !== want.bad_modulus) begin
                  $error("bad_modulus mismatch: expected %0b, got %0b",
                         want.bad_modulus, rsp_bad_modulus);
                  errors++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            moved = 1'b1;
            want  = jacobi_of(req_n_value, req_m_value);
            pending_symbols.push_back(want);
            items_sent++;
            if (want.bad_modulus)
               bad_mod_seen++;
            else if (want.symbol == SYM_NEG)
               neg_seen++;
            else if (want.symbol == SYM_ZERO)
               zero_seen++;
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no beat moved for %0d cycles", QUIET_LIMIT);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // offer one item; returns at the edge where it is taken
   task automatic send_item(logic signed [N_W-1:0] n, logic [M_W-1:0] m);
      while ($urandom_range(99) < source_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
         @(posedge clock);
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_n_value <= n;
      req_m_value <= m;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain_results();
      do @(posedge clock); while (pending_symbols.size() != 0);
   endtask

   task automatic pick_operands(output logic signed [N_W-1:0] n, output logic [M_W-1:0] m);
      int unsigned kind;
      longint      k;
      kind = $urandom_range(99);
      if (kind < 8)
         m = M_W'($urandom) & ~M_W'(1);
      else if (kind < 11)
         m = M_W'(1);
      else if (kind < 45)
         m = M_W'($urandom_range(255, 3)) | M_W'(1);
      else if (kind < 70)
         m = M_W'($urandom_range(65535, 257)) | M_W'(1);
      else
         m = M_W'($urandom) | M_W'(1);
      kind = $urandom_range(99);
      if (kind < 60) begin
         n = $urandom;
      end else if (kind < 75) begin
         n = int'($urandom_range(2000)) - 1000;
      end else if (kind < 90) begin
         // exact multiple of the modulus, either sign
         if (m < 65536)
            k = longint'($urandom_range(60000)) - 30000;
         else
            k = longint'($urandom_range(2)) - 1;
         n = N_W'(k * longint'(m));
      end else begin
         // shared factor of three, never coprime
         m = M_W'(3 * (2 * longint'($urandom_range(300000)) + 1));
         k = longint'($signed($urandom)) / 4;
         n = N_W'(3 * k);
      end
   endtask

   task automatic test_directed();
      source_idle_pct = 0;
      sink_stall_pct  = 0;
      send_item(0, 1);
      send_item(32'sh8000_0000, 1);
      send_item(5, 0);
      send_item(-7, 2);
      send_item(32'sh7fff_ffff, 31'h7fff_fffe);
      send_item(32'sh7fff_ffff, 31'h7fff_ffff);
      send_item(32'sh8000_0000, 31'h7fff_ffff);
      send_item(-1, 31'h7fff_ffff);
      send_item(32'sh7fff_ffff, 31'h7fff_fffd);
      send_item(2, 7);
      send_item(2, 3);
      send_item(-1, 3);
      send_item(-1, 5);
      send_item(15, 21);
      send_item(0, 9);
      send_item(9, 9);
      send_item(-9, 3);
      send_item(1001, 9907);
      send_item(19, 45);
      send_item(8, 21);
      send_item(30, 1);
      send_item(32'sh5555_5555, 31'h2aaa_aaab);
      send_item(32'shaaaa_aaaa, 31'h5555_5555);
      send_item(-2, 31'h4000_0001);
   endtask

   task automatic test_random(int count, int src_pct, int sink_pct);
      logic signed [N_W-1:0] n;
      logic        [M_W-1:0] m;
      source_idle_pct = src_pct;
      sink_stall_pct  = sink_pct;
      repeat (count) begin
         pick_operands(n, m);
         send_item(n, m);
      end
   endtask

   // sink holds off while the source keeps offering, so the unit backs up
   task automatic test_backpressure();
      logic signed [N_W-1:0] n;
      logic        [M_W-1:0] m;
      source_idle_pct = 0;
      sink_stall_pct  = 20;
      hold_request    = 1'b1;
      repeat (24) begin
         pick_operands(n, m);
         send_item(n, m);
      end
   endtask

   // source pauses until every outstanding result is back
   task automatic test_drain_pause();
      logic signed [N_W-1:0] n;
      logic        [M_W-1:0] m;
      source_idle_pct = 5;
      sink_stall_pct  = 30;
      repeat (20) begin
         pick_operands(n, m);
         send_item(n, m);
      end
      @(negedge clock);
      req_valid <= 1'b0;
      drain_results();
      repeat (20) begin
         pick_operands(n, m);
         send_item(n, m);
      end
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_n_value     = '0;
      req_m_value     = M_W'(1);
      errors          = 0;
      items_sent      = 0;
      beats_checked   = 0;
      bad_mod_seen    = 0;
      neg_seen        = 0;
      zero_seen       = 0;
      quiet_cycles    = 0;
      source_idle_pct = 0;
      sink_stall_pct  = 0;
      hold_request    = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(450, 12, 65);
      test_drain_pause();
      test_random(450, 65, 12);
      test_backpressure();
      test_random(450, 0, 0);

      @(negedge clock);
      req_valid <= 1'b0;
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_symbols.size() != 0) begin
         $error("%0d results never arrived", pending_symbols.size());
         errors++;
      end

      $display("covered %0d items, %0d beats checked: %0d even moduli, %0d symbols of -1, %0d of 0",
               items_sent, beats_checked, bad_mod_seen, neg_seen, zero_seen);
      $display("idling mixes 12/65, 65/12 and none, plus a %0d-cycle sink hold-off and a drain",
               HOLD_CYCLES);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/jsu_pkg.sv
rtl/jsu_ctrl.sv
rtl/jsu_dp.sv
rtl/jacobi_symbol_unit.sv
dv/jacobi_symbol_unit_test.sv
